// ----- sv/mhe_pkg.sv -----
// Package: word types, entry format and MessagePack header codes for the header encoder.
`default_nettype none
package mhe_pkg;

   typedef enum logic [1:0] {
      MODE_INT   = 2'd0,
      MODE_ARRAY = 2'd1,
      MODE_MAP   = 2'd2,
      MODE_STR   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [63:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } rsp_type;

   // classified item as it sits in the queue
   typedef struct packed {
      logic        err;
      logic [7:0]  head;
      logic [3:0]  nbytes;
      logic [63:0] payload;
   } entry_type;

   localparam int QDEPTH = 2;

   localparam logic [7:0] FIX_MAP    = 8'h80;
   localparam logic [7:0] FIX_ARRAY  = 8'h90;
   localparam logic [7:0] FIX_STR    = 8'hA0;
   localparam logic [7:0] HEAD_U8    = 8'hCC;
   localparam logic [7:0] HEAD_U16   = 8'hCD;
   localparam logic [7:0] HEAD_U32   = 8'hCE;
   localparam logic [7:0] HEAD_U64   = 8'hCF;
   localparam logic [7:0] HEAD_I8    = 8'hD0;
   localparam logic [7:0] HEAD_I16   = 8'hD1;
   localparam logic [7:0] HEAD_I32   = 8'hD2;
   localparam logic [7:0] HEAD_I64   = 8'hD3;
   localparam logic [7:0] HEAD_STR8  = 8'hD9;
   localparam logic [7:0] HEAD_STR16 = 8'hDA;
   localparam logic [7:0] HEAD_STR32 = 8'hDB;
   localparam logic [7:0] HEAD_ARR16 = 8'hDC;
   localparam logic [7:0] HEAD_ARR32 = 8'hDD;
   localparam logic [7:0] HEAD_MAP16 = 8'hDE;
   localparam logic [7:0] HEAD_MAP32 = 8'hDF;

endpackage
`default_nettype wire

// ----- sv/mhe_classify.sv -----
// Front end: picks the header byte, payload length and error flag for one request word.
`default_nettype none
module mhe_classify
   import mhe_pkg::*;
(
   input  req_type   req,
   output entry_type ent
);

   logic [63:0] u;

   always_comb begin
      u           = req.value;
      ent.err     = 1'b0;
      ent.head    = 8'h00;
      ent.nbytes  = 4'd0;
      ent.payload = u;
      case (req.mode)
         MODE_INT: begin
            if (!u[63]) begin
               if (~|u[63:7]) begin
                  ent.head = u[7:0];
               end else if (~|u[63:8]) begin
                  ent.head = HEAD_U8;  ent.nbytes = 4'd1;
               end else if (~|u[63:16]) begin
                  ent.head = HEAD_U16; ent.nbytes = 4'd2;
               end else if (~|u[63:32]) begin
                  ent.head = HEAD_U32; ent.nbytes = 4'd4;
               end else begin
                  ent.head = HEAD_U64; ent.nbytes = 4'd8;
               end
            end else begin
               // negative: sign run length picks the form
               if (&u[63:5]) begin
                  ent.head = u[7:0];
               end else if (&u[63:7]) begin
                  ent.head = HEAD_I8;  ent.nbytes = 4'd1;
               end else if (&u[63:15]) begin
                  ent.head = HEAD_I16; ent.nbytes = 4'd2;
               end else if (&u[63:31]) begin
                  ent.head = HEAD_I32; ent.nbytes = 4'd4;
               end else begin
                  ent.head = HEAD_I64; ent.nbytes = 4'd8;
               end
            end
         end
         MODE_ARRAY: begin
            if (|u[63:32]) begin
               ent.err = 1'b1;
            end else if (~|u[31:4]) begin
               ent.head = FIX_ARRAY | {4'b0000, u[3:0]};
            end else if (~|u[31:16]) begin
               ent.head = HEAD_ARR16; ent.nbytes = 4'd2;
            end else begin
               ent.head = HEAD_ARR32; ent.nbytes = 4'd4;
            end
         end
         MODE_MAP: begin
            if (|u[63:32]) begin
               ent.err = 1'b1;
            end else if (~|u[31:4]) begin
               ent.head = FIX_MAP | {4'b0000, u[3:0]};
            end else if (~|u[31:16]) begin
               ent.head = HEAD_MAP16; ent.nbytes = 4'd2;
            end else begin
               ent.head = HEAD_MAP32; ent.nbytes = 4'd4;
            end
         end
         MODE_STR: begin
            if (|u[63:32]) begin
               ent.err = 1'b1;
            end else if (~|u[31:5]) begin
               ent.head = FIX_STR | {3'b000, u[4:0]};
            end else if (~|u[31:8]) begin
               ent.head = HEAD_STR8;  ent.nbytes = 4'd1;
            end else if (~|u[31:16]) begin
               ent.head = HEAD_STR16; ent.nbytes = 4'd2;
            end else begin
               ent.head = HEAD_STR32; ent.nbytes = 4'd4;
            end
         end
         default: begin
            ent.err = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/mhe_queue.sv -----
// Two-entry queue of classified items between the front end and the byte serializer.
`default_nettype none
module mhe_queue
   import mhe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_ent,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head_ent
);

   localparam int PW = $clog2(QDEPTH);
   localparam int CW = $clog2(QDEPTH + 1);

   entry_type         slot_ff [QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(QDEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_ent  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_ent;
      end
   end

endmodule
`default_nettype wire

// ----- sv/mhe_serialize.sv -----
// Back end: emits the header byte, then the payload bytes most significant first.
`default_nettype none
module mhe_serialize
   import mhe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  entry_type q_ent,
   output logic      q_pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic        busy_ff, busy_in;
   logic [3:0]  remain_ff, remain_in;
   logic [63:0] pay_ff, pay_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        adv;
   logic [2:0]  idx;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign idx       = remain_ff[2:0] - 3'd1;   // remain of 8 wraps to byte 7
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      busy_in      = busy_ff;
      remain_in    = remain_ff;
      pay_in       = pay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      if (adv) begin
         if (busy_ff) begin
            rsp_valid_in         = 1'b1;
            rsp_data_in.out_byte = pay_ff[{idx, 3'b000} +: 8];
            rsp_data_in.last     = (remain_ff == 4'd1);
            rsp_data_in.error    = 1'b0;
            remain_in            = remain_ff - 4'd1;
            busy_in              = (remain_ff != 4'd1);
         end else if (q_valid) begin
            q_pop                = 1'b1;
            rsp_valid_in         = 1'b1;
            rsp_data_in.out_byte = q_ent.err ? 8'h00 : q_ent.head;
            rsp_data_in.last     = q_ent.err || (q_ent.nbytes == 4'd0);
            rsp_data_in.error    = q_ent.err;
            pay_in               = q_ent.payload;
            remain_in            = q_ent.nbytes;
            busy_in              = !q_ent.err && (q_ent.nbytes != 4'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff   <= remain_in;
      pay_ff      <= pay_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ----- sv/msgpack_header_encoder.sv -----
// Top level: MessagePack header encoder, request words in, encoded bytes out.
//
//   channel  direction  handshake                word
//   req_     in         req_valid / req_ready    req_type  (mode, value)
//   rsp_     out        rsp_valid / rsp_ready    rsp_type  (out_byte, last, error)
//
// One output byte per cycle while rsp_ready is high; an item is its header plus
// 0 to 8 payload bytes. The serializer is the only rate limit; a bad length gives
// one error byte. The front end classifies at accept and writes a two-entry
// queue; bytes then pass the output register. Stalls on rsp_ready fill the queue,
// then drop req_ready. Synchronous reset empties queue and output register.
`default_nettype none
module msgpack_header_encoder
   import mhe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   entry_type cls_ent;
   entry_type q_ent;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;
   logic      push;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   mhe_classify u_classify (
      .req (req_data),
      .ent (cls_ent)
   );

   mhe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_ent  (cls_ent),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_ent  (q_ent)
   );

   mhe_serialize u_serialize (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ent     (q_ent),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- sv/mhe_checker.sv -----
// Port-level checks for the header encoder, bound to the top level.
`default_nettype none
module mhe_checker
   import mhe_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // bytes already taken of the item in flight
   logic [3:0] taken_ff, taken_in;

   always_comb begin
      taken_in = taken_ff;
      if (rsp_valid && rsp_ready) begin
         taken_in = rsp_data.last ? 4'd0 : taken_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= 4'd0;
      end else begin
         taken_ff <= taken_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.last && (rsp_data.out_byte == 8'h00)
         && (taken_ff == 4'd0))
      else $error("error word malformed");

   a_max_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (taken_ff == 4'd8) |-> rsp_data.last)
      else $error("item longer than nine bytes");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_ready && !rsp_valid)
      else $error("not idle after reset");

   logic unused_ok;
   assign unused_ok = req_valid ^ (^req_data);

endmodule

bind msgpack_header_encoder mhe_checker u_mhe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
